// ===== design/host_membership_set_defines.svh =====
// ----------------------------------------------------------------------------
// host membership set assertion macros
// shared concurrent assertion forms for the membership set rtl
// ----------------------------------------------------------------------------
`ifndef HOST_MEMBERSHIP_SET_DEFINES_SVH
`define HOST_MEMBERSHIP_SET_DEFINES_SVH

// checked outside reset
`define HMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge
`define HMS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/hms_pkg.sv =====
// ----------------------------------------------------------------------------
// hms_pkg
// types and codes shared by the host membership set modules
// ----------------------------------------------------------------------------
package hms_pkg;

    localparam int HostW = 16;

    typedef enum logic [1:0] {
        OP_ADD        = 2'd0,
        OP_VERIFY     = 2'd1,
        OP_REMOVE     = 2'd2,
        OP_REMOVE_ALL = 2'd3
    } op_e;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_FINAL
    } state_e;

    typedef struct packed {
        logic [1:0]       operation;
        logic [HostW-1:0] host_id;
        logic             notify;
    } in_item_t;

    typedef struct packed {
        logic             was_present;
        logic             store_full;
        logic             notice_valid;
        logic [HostW-1:0] notice_host;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic insert_en;
        logic remove_en;
        logic shift_en;
    } cell_cmd_t;

endpackage

// ===== design/hms_cell.sv =====
// ----------------------------------------------------------------------------
// hms_cell
// one slot of the set: valid bit, stored host, match and free-slot chain
// ----------------------------------------------------------------------------
module hms_cell #(
    parameter int HOST_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hms_pkg::cell_cmd_t    cmd,
    input  logic [HOST_BITS-1:0]  key,
    input  logic                  free_below_in,
    output logic                  free_below_out,
    input  logic                  up_valid,
    input  logic [HOST_BITS-1:0]  up_host,
    output logic                  valid,
    output logic [HOST_BITS-1:0]  host,
    output logic                  match
);
    import hms_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [HOST_BITS-1:0] host_reg;
    logic [HOST_BITS-1:0] host_next;
    logic                 ins_here;

    assign match          = valid_reg && (host_reg == key);
    assign ins_here       = !valid_reg && !free_below_in;
    assign free_below_out = free_below_in || !valid_reg;
    assign valid          = valid_reg;
    assign host           = host_reg;

    always_comb
    begin
        valid_next = valid_reg;
        host_next  = host_reg;
        if (cmd.shift_en)
        begin
            valid_next = up_valid;
            host_next  = up_host;
        end
        else if (cmd.insert_en && ins_here)
        begin
            valid_next = 1'b1;
            host_next  = key;
        end
        else if (cmd.remove_en && match)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        host_reg <= host_next;
    end

endmodule

// ===== design/hms_chain.sv =====
// ----------------------------------------------------------------------------
// hms_chain
// row of slot cells, lowest slot at the head, shifting toward the head
// ----------------------------------------------------------------------------
module hms_chain #(
    parameter int CAPACITY  = 32,
    parameter int HOST_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hms_pkg::cell_cmd_t    cmd,
    input  logic [HOST_BITS-1:0]  key,
    output logic                  any_match,
    output logic                  full,
    output logic                  occupied,
    output logic                  head_valid,
    output logic [HOST_BITS-1:0]  head_host
);
    import hms_pkg::*;

    logic [CAPACITY:0]    free_w;
    logic [CAPACITY:0]    valid_w;
    logic [HOST_BITS-1:0] host_w [CAPACITY+1];
    logic [CAPACITY-1:0]  match_w;

    assign free_w[0]          = 1'b0;
    assign valid_w[CAPACITY]  = 1'b0;
    assign host_w[CAPACITY]   = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        hms_cell #(
            .HOST_BITS (HOST_BITS)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cmd            (cmd),
            .key            (key),
            .free_below_in  (free_w[i]),
            .free_below_out (free_w[i+1]),
            .up_valid       (valid_w[i+1]),
            .up_host        (host_w[i+1]),
            .valid          (valid_w[i]),
            .host           (host_w[i]),
            .match          (match_w[i])
        );
    end

    assign any_match  = |match_w;
    assign full       = !free_w[CAPACITY];
    assign occupied   = |valid_w[CAPACITY-1:0];
    assign head_valid = valid_w[0];
    assign head_host  = host_w[0];

endmodule

// ===== design/host_membership_set.sv =====
// ----------------------------------------------------------------------------
// host_membership_set
// bounded set of host identifiers with add, verify, remove and remove all
// ----------------------------------------------------------------------------
// Add, verify and remove capture the beat first; then, once the output
// register is free, every slot cell compares against the host in parallel
// and the lowest free slot is found along the cell row. Remove all shifts
// the cell row toward slot 0 once per cycle while the output side does not
// stall a notice, reading slot 0 out. Any item waits further for as long
// as the output side stalls a result that is already waiting. Only one item
// is in work at a time; a finished result waits in the output register
// while the next beat is taken. Configuration is always ready.
`include "host_membership_set_defines.svh"

module host_membership_set #(
    parameter int CAPACITY  = 32,
    parameter int HOST_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hms_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hms_pkg::out_item_t   out_data
);
    import hms_pkg::*;

    localparam int CntW     = $clog2(CAPACITY);
    localparam int CopyBits = (HOST_BITS < HostW) ? HOST_BITS : HostW;

    state_e               state_reg;
    state_e               state_next;
    logic                 listener_reg;
    in_item_t             cmd_reg;
    logic [CntW-1:0]      cnt_reg;
    logic [CntW-1:0]      cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_item_t            out_data_reg;
    out_item_t            out_data_next;
    logic                 load_out;
    logic                 out_free;
    logic                 tell;
    logic                 step;
    op_e                  op;
    cell_cmd_t            cell_cmd;
    logic [HOST_BITS-1:0] key;
    logic [HostW-1:0]     key_narrow;
    logic [HostW-1:0]     head_narrow;
    logic                 any_match;
    logic                 full;
    logic                 occupied;
    logic                 head_valid;
    logic [HOST_BITS-1:0] head_host;

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;
    assign op          = op_e'(cmd_reg.operation);
    assign tell        = cmd_reg.notify && listener_reg;
    assign out_free    = !out_valid_reg || out_ready;
    assign step        = !(head_valid && tell) || out_free;
    assign key         = HOST_BITS'(cmd_reg.host_id[CopyBits-1:0]);
    assign key_narrow  = HostW'(key[CopyBits-1:0]);
    assign head_narrow = HostW'(head_host[CopyBits-1:0]);

    hms_chain #(
        .CAPACITY  (CAPACITY),
        .HOST_BITS (HOST_BITS)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cell_cmd),
        .key        (key),
        .any_match  (any_match),
        .full       (full),
        .occupied   (occupied),
        .head_valid (head_valid),
        .head_host  (head_host)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op == OP_REMOVE_ALL)
                begin
                    state_next = S_SWEEP;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                if (step && (cnt_reg == CntW'(CAPACITY - 1)))
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cell_cmd      = '0;
        load_out      = 1'b0;
        out_data_next = '0;
        cnt_next      = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = '0;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    unique case (op) inside
                        OP_ADD:
                        begin
                            load_out                  = 1'b1;
                            out_data_next.last        = 1'b1;
                            out_data_next.was_present = any_match;
                            out_data_next.store_full  = !any_match && full;
                            cell_cmd.insert_en        = !any_match;
                        end
                        OP_VERIFY, OP_REMOVE:
                        begin
                            load_out                   = 1'b1;
                            out_data_next.last         = 1'b1;
                            out_data_next.was_present  = any_match;
                            out_data_next.notice_valid = tell;
                            out_data_next.notice_host  = tell ? key_narrow : '0;
                            cell_cmd.remove_en         = (op == OP_REMOVE);
                        end
                        OP_REMOVE_ALL:
                        begin
                            load_out = 1'b0;
                        end
                        default:
                        begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                if (step)
                begin
                    cell_cmd.shift_en = 1'b1;
                    cnt_next          = cnt_reg + CntW'(1);
                    if (head_valid && tell)
                    begin
                        load_out                   = 1'b1;
                        out_data_next.notice_valid = 1'b1;
                        out_data_next.notice_host  = head_narrow;
                    end
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    load_out           = 1'b1;
                    out_data_next.last = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            listener_reg  <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                listener_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= in_data;
        end
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `HMS_ASSERT(a_one_item_in_work, in_valid && in_ready |=> !in_ready,
                "second beat taken while busy")
    `HMS_ASSERT(a_full_result_shape,
                out_valid && out_data.store_full |-> out_data.last && !out_data.was_present,
                "bad refused add result")
    `HMS_ASSERT(a_sweep_clears_row, (state_reg == S_FINAL) |-> !occupied,
                "slots left after remove all sweep")
    `HMS_ASSERT(a_sweep_notice_shape,
                out_valid && out_data.notice_valid && !out_data.last |->
                    !out_data.was_present && !out_data.store_full,
                "bad remove all notice")

endmodule

// ===== bench/host_membership_set_tb.sv =====
// ----------------------------------------------------------------------------
// host_membership_set_tb
// self-checking bench for the bounded host membership set
// ----------------------------------------------------------------------------
// A directed opening covers add, verify, remove and remove all, duplicate adds,
// notices with and without the listener, and sweeps of occupied and empty stores.
// Random phases follow, mostly from a small pool of hosts so that hits,
// misses, full-store refusals and long remove-all sweeps all occur. The
// sender idles and the receiver stalls at random. A set model predicts every
// result beat, and the monitor compares each one field by field.
// ----------------------------------------------------------------------------
module host_membership_set_tb;
    import hms_pkg::*;

    localparam int CAP        = 32;
    localparam int POOL       = 40;
    localparam int QUIET_MAX  = 4000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    in_item_t  beats_to_send[$];
    out_item_t results_due[$];
    out_item_t want;

    logic        member_valid[CAP];
    logic [15:0] member_host[CAP];
    logic        listener_on;
    logic [15:0] host_pool[POOL];

    int unsigned idle_pct;
    int unsigned stall_pct;
    bit          drain_each;
    int unsigned quiet;
    int unsigned err_count;

    host_membership_set uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    // set model: one accepted request beat in, its result beats queued
    function automatic void apply_to_set(input in_item_t req);
        int        hit;
        int        free_slot;
        bit        tell;
        out_item_t res;
        out_item_t note;
        hit = -1;
        free_slot = -1;
        tell = req.notify && listener_on;
        for (int i = 0; i < CAP; i++)
        begin
            if (hit < 0 && member_valid[i] && member_host[i] == req.host_id)
                hit = i;
        end
        res = '0;
        res.last = 1'b1;
        case (op_e'(req.operation)) inside
            OP_ADD:
            begin
                if (hit >= 0)
                    res.was_present = 1'b1;
                else
                begin
                    for (int i = CAP - 1; i >= 0; i--)
                    begin
                        if (!member_valid[i])
                            free_slot = i;
                    end
                    if (free_slot >= 0)
                    begin
                        member_valid[free_slot] = 1'b1;
                        member_host[free_slot] = req.host_id;
                    end
                    else
                        res.store_full = 1'b1;
                end
            end
            OP_VERIFY, OP_REMOVE:
            begin
                res.was_present = (hit >= 0);
                if (op_e'(req.operation) == OP_REMOVE && hit >= 0)
                    member_valid[hit] = 1'b0;
                if (tell)
                begin
                    res.notice_valid = 1'b1;
                    res.notice_host = req.host_id;
                end
            end
            default:
            begin
                for (int i = 0; i < CAP; i++)
                begin
                    if (member_valid[i])
                    begin
                        if (tell)
                        begin
                            note = '0;
                            note.notice_valid = 1'b1;
                            note.notice_host = member_host[i];
                            results_due.push_back(note);
                        end
                        member_valid[i] = 1'b0;
                    end
                end
            end
        endcase
        results_due.push_back(res);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_to_set(in_data);
            if (!in_valid || in_ready)
            begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= idle_pct
                        && !(drain_each && results_due.size() != 0))
                begin
                    in_valid <= 1'b1;
                    in_data <= beats_to_send.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            err_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
        end
    endfunction

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected beat, expected none actual %h", $time, out_data);
            end
            else
            begin
                want = results_due.pop_front();
                check_field("was_present", int'(want.was_present),
                            int'(out_data.was_present));
                check_field("store_full", int'(want.store_full),
                            int'(out_data.store_full));
                check_field("notice_valid", int'(want.notice_valid),
                            int'(out_data.notice_valid));
                check_field("notice_host", int'(want.notice_host),
                            int'(out_data.notice_host));
                check_field("last", int'(want.last), int'(out_data.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_MAX)
            begin
                $display("host_membership_set_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic send(input op_e op, input logic [15:0] host, input logic notify);
        in_item_t req;
        req.operation = op;
        req.host_id = host;
        req.notify = notify;
        beats_to_send.push_back(req);
    endtask

    task automatic wait_idle();
        while (beats_to_send.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_listener(input logic value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        listener_on = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        int sent;
        int roll;
        int base;
        sent = 0;
        for (int i = 0; i < POOL; i++)
            host_pool[i] = 16'($urandom);
        while (sent < count)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
            begin
                send(OP_REMOVE_ALL, 16'($urandom), 1'($urandom_range(1)));
                sent++;
            end
            else if (roll < 7)
            begin
                // fill burst, runs past capacity
                base = $urandom_range(POOL - 1);
                for (int k = 0; k < CAP + 2; k++)
                    send(OP_ADD, host_pool[(base + k) % POOL], 1'($urandom_range(1)));
                sent += CAP + 2;
            end
            else
            begin
                roll = $urandom_range(99);
                send(roll < 45 ? OP_ADD : (roll < 70 ? OP_VERIFY : OP_REMOVE),
                     $urandom_range(9) == 0 ? 16'($urandom)
                                            : host_pool[$urandom_range(POOL - 1)],
                     1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        drain_each = 1'b1;
        quiet = 0;
        err_count = 0;
        listener_on = 1'b0;
        for (int i = 0; i < CAP; i++)
        begin
            member_valid[i] = 1'b0;
            member_host[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, one request at a time
        set_listener(1'b1);
        send(OP_ADD, 16'h0000, 1'b0);
        send(OP_ADD, 16'hFFFF, 1'b1);
        send(OP_ADD, 16'h0000, 1'b1);
        send(OP_VERIFY, 16'h0000, 1'b1);
        send(OP_VERIFY, 16'h1234, 1'b1);
        send(OP_VERIFY, 16'hFFFF, 1'b0);
        send(OP_REMOVE, 16'hFFFF, 1'b1);
        send(OP_REMOVE, 16'hFFFF, 1'b0);
        send(OP_ADD, 16'hA5A5, 1'b0);
        send(OP_ADD, 16'h5A5A, 1'b0);
        send(OP_REMOVE_ALL, 16'hFFFF, 1'b1);
        send(OP_REMOVE_ALL, 16'h0000, 1'b1);
        send(OP_VERIFY, 16'h0000, 1'b0);
        send(OP_ADD, 16'h8001, 1'b0);
        send(OP_REMOVE_ALL, 16'h0000, 1'b0);
        set_listener(1'b0);
        send(OP_ADD, 16'h1111, 1'b1);
        send(OP_VERIFY, 16'h1111, 1'b1);
        send(OP_REMOVE, 16'h7FFE, 1'b1);
        send(OP_ADD, 16'h2222, 1'b0);
        send(OP_REMOVE_ALL, 16'h0000, 1'b1);
        send(OP_REMOVE, 16'h1111, 1'b1);
        wait_idle();
        drain_each = 1'b0;

        set_listener(1'b1);
        queue_random(55);
        wait_idle();

        idle_pct = 86;
        set_listener(1'b0);
        queue_random(55);
        wait_idle();

        idle_pct = 0;
        stall_pct = 86;
        set_listener(1'b1);
        queue_random(55);
        wait_idle();

        idle_pct = 19;
        stall_pct = 19;
        set_listener(1'b1);
        queue_random(55);
        wait_idle();

        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("host_membership_set_tb: done, clean");
        else
            $display("host_membership_set_tb: done, errors");
        $finish;
    end

endmodule
